// ----- hw/rtl/imass_pkg.sv -----
// Shared widths, types and a helper function for the two-particle invariant mass pipeline.
package imass_pkg;

   localparam int COMPONENT_WIDTH = 20;
   localparam int SUM_WIDTH       = COMPONENT_WIDTH + 1;
   localparam int SQ_WIDTH        = 2 * COMPONENT_WIDTH + 1;
   localparam int P2_WIDTH        = 2 * COMPONENT_WIDTH + 2;
   localparam int ROOT_WIDTH      = COMPONENT_WIDTH + 1;
   localparam int RAD_WIDTH       = 2 * ROOT_WIDTH;
   localparam int REM_WIDTH       = ROOT_WIDTH + 2;
   localparam int MASS_WIDTH      = 21;
   localparam int EXT_WIDTH       = (ROOT_WIDTH > MASS_WIDTH) ? ROOT_WIDTH : MASS_WIDTH;
   localparam int FRONT_STAGES    = 4;
   localparam int PIPE_DEPTH      = FRONT_STAGES + ROOT_WIDTH + 1;

   typedef logic signed [COMPONENT_WIDTH-1:0] component_type;
   typedef logic signed [SUM_WIDTH-1:0]       sum_type;
   typedef logic        [SUM_WIDTH-1:0]       mag_type;
   typedef logic        [SQ_WIDTH-1:0]        square_type;
   typedef logic        [P2_WIDTH-1:0]        p2_type;
   typedef logic        [ROOT_WIDTH-1:0]      root_type;
   typedef logic        [MASS_WIDTH-1:0]      mass_type;

   localparam mass_type MASS_MAX = '1;

   // State carried through the digit-by-digit square root stages
   typedef struct packed {
      logic [REM_WIDTH-1:0] rem;
      root_type             root;
      logic [RAD_WIDTH-1:0] rad;
      logic                 spacelike;
      logic                 last;
   } root_state_type;

   // Clamp the root to the output width
   function automatic mass_type sat_mass(input root_type r);
      logic [EXT_WIDTH-1:0] ext;
      ext = EXT_WIDTH'(r);
      if (ext > EXT_WIDTH'(MASS_MAX)) begin
         return MASS_MAX;
      end
      return ext[MASS_WIDTH-1:0];
   endfunction

endpackage

// ----- hw/rtl/imass_if.sv -----
// Valid/ready channel interfaces for the event input and the mass result.
interface imass_req_if;
   logic                     valid;
   logic                     ready;
   imass_pkg::component_type energy_first;
   imass_pkg::component_type px_first;
   imass_pkg::component_type py_first;
   imass_pkg::component_type pz_first;
   imass_pkg::component_type energy_second;
   imass_pkg::component_type px_second;
   imass_pkg::component_type py_second;
   imass_pkg::component_type pz_second;
   logic                     last_event;

   modport source (
      output valid, energy_first, px_first, py_first, pz_first,
             energy_second, px_second, py_second, pz_second, last_event,
      input  ready
   );
   modport sink (
      input  valid, energy_first, px_first, py_first, pz_first,
             energy_second, px_second, py_second, pz_second, last_event,
      output ready
   );
endinterface

interface imass_rsp_if;
   logic                valid;
   logic                ready;
   imass_pkg::mass_type invariant_mass;
   logic                spacelike_flag;
   logic                last_event_out;

   modport source (
      output valid, invariant_mass, spacelike_flag, last_event_out,
      input  ready
   );
   modport sink (
      input  valid, invariant_mass, spacelike_flag, last_event_out,
      output ready
   );
endinterface

// ----- hw/rtl/invariant_mass_two_particles_top.sv -----
// Top level: pipelined invariant mass of two summed four-momenta.
//
//   channel   direction  carries                                       handshake
//   req_chan  in         two four-momenta, last_event                  valid/ready
//   rsp_chan  out        invariant_mass, spacelike_flag, last_event_out valid/ready
//
// One event enters per cycle unless a result-side stall backs up the pipe; an input passes
// through 26 registers (four arithmetic stages, one stage per square root bit, one output
// register) before its result is shown.
// The square root takes one root bit per stage, 21 stages, and sets the latency.
// Synchronous reset empties every stage; payload registers are not reset.
// A stall on the result side holds only the stages behind a full stage; empty
// stages keep filling, so input transfers continue until the whole pipe is full.
module invariant_mass_two_particles_top (
   input  logic               clock,
   input  logic               reset,
   imass_req_if.sink          req_chan,
   imass_rsp_if.source        rsp_chan
);

   localparam int R = imass_pkg::ROOT_WIDTH;

   // Stage A: component sums, as magnitudes
   logic                 a_valid_ff, a_valid_in, a_ready;
   imass_pkg::mag_type   a_e_ff, a_x_ff, a_y_ff, a_z_ff;
   imass_pkg::mag_type   a_e_in, a_x_in, a_y_in, a_z_in;
   logic                 a_last_ff;
   imass_pkg::sum_type   se, sx, sy, sz;

   // Stage B: squares
   logic                   b_valid_ff, b_valid_in, b_ready;
   imass_pkg::square_type  b_e2_ff, b_x2_ff, b_y2_ff, b_z2_ff;
   imass_pkg::square_type  b_e2_in, b_x2_in, b_y2_in, b_z2_in;
   logic                   b_last_ff;

   // Stage C: momentum sum
   logic                   c_valid_ff, c_valid_in, c_ready;
   imass_pkg::square_type  c_e2_ff;
   imass_pkg::p2_type      c_p2_ff, c_p2_in;
   logic                   c_last_ff;

   // Stage D: mass squared and sign
   logic                      d_valid_ff, d_valid_in, d_ready;
   imass_pkg::root_state_type d_state_ff, d_state_in;
   logic                      spacelike;

   // Root stages
   logic                      root_valid [R];
   logic                      root_ready [R];
   imass_pkg::root_state_type root_state [R];

   // Output register
   logic                 o_valid_ff, o_valid_in, o_ready;
   imass_pkg::mass_type  o_mass_ff, o_mass_in;
   logic                 o_flag_ff, o_last_ff;

   // Ready chain: a stage takes new data when empty or when it moves on
   assign o_ready  = !o_valid_ff || rsp_chan.ready;
   assign d_ready  = !d_valid_ff || root_ready[0];
   assign c_ready  = !c_valid_ff || d_ready;
   assign b_ready  = !b_valid_ff || c_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign req_chan.ready = a_ready;

   assign a_valid_in = a_ready ? req_chan.valid : a_valid_ff;
   assign b_valid_in = b_ready ? a_valid_ff     : b_valid_ff;
   assign c_valid_in = c_ready ? b_valid_ff     : c_valid_ff;
   assign d_valid_in = d_ready ? c_valid_ff     : d_valid_ff;
   assign o_valid_in = o_ready ? root_valid[R-1] : o_valid_ff;

   always_comb begin
      se = imass_pkg::sum_type'(req_chan.energy_first) +
           imass_pkg::sum_type'(req_chan.energy_second);
      sx = imass_pkg::sum_type'(req_chan.px_first) +
           imass_pkg::sum_type'(req_chan.px_second);
      sy = imass_pkg::sum_type'(req_chan.py_first) +
           imass_pkg::sum_type'(req_chan.py_second);
      sz = imass_pkg::sum_type'(req_chan.pz_first) +
           imass_pkg::sum_type'(req_chan.pz_second);
      a_e_in = se[imass_pkg::SUM_WIDTH-1] ? imass_pkg::mag_type'(-se) : imass_pkg::mag_type'(se);
      a_x_in = sx[imass_pkg::SUM_WIDTH-1] ? imass_pkg::mag_type'(-sx) : imass_pkg::mag_type'(sx);
      a_y_in = sy[imass_pkg::SUM_WIDTH-1] ? imass_pkg::mag_type'(-sy) : imass_pkg::mag_type'(sy);
      a_z_in = sz[imass_pkg::SUM_WIDTH-1] ? imass_pkg::mag_type'(-sz) : imass_pkg::mag_type'(sz);
   end

   always_comb begin
      b_e2_in = imass_pkg::SQ_WIDTH'(a_e_ff * a_e_ff);
      b_x2_in = imass_pkg::SQ_WIDTH'(a_x_ff * a_x_ff);
      b_y2_in = imass_pkg::SQ_WIDTH'(a_y_ff * a_y_ff);
      b_z2_in = imass_pkg::SQ_WIDTH'(a_z_ff * a_z_ff);
   end

   assign c_p2_in = imass_pkg::P2_WIDTH'(b_x2_ff) + imass_pkg::P2_WIDTH'(b_y2_ff) +
                    imass_pkg::P2_WIDTH'(b_z2_ff);

   // Negative mass squared: start the root from zero and flag it
   always_comb begin
      spacelike            = imass_pkg::P2_WIDTH'(c_e2_ff) < c_p2_ff;
      d_state_in.rem       = '0;
      d_state_in.root      = '0;
      d_state_in.spacelike = spacelike;
      d_state_in.last      = c_last_ff;
      if (spacelike) begin
         d_state_in.rad = '0;
      end else begin
         d_state_in.rad = imass_pkg::RAD_WIDTH'(
            imass_pkg::SQ_WIDTH'(imass_pkg::P2_WIDTH'(c_e2_ff) - c_p2_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
         d_valid_ff <= d_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && req_chan.valid) begin
         a_e_ff    <= a_e_in;
         a_x_ff    <= a_x_in;
         a_y_ff    <= a_y_in;
         a_z_ff    <= a_z_in;
         a_last_ff <= req_chan.last_event;
      end
      if (b_ready && a_valid_ff) begin
         b_e2_ff   <= b_e2_in;
         b_x2_ff   <= b_x2_in;
         b_y2_ff   <= b_y2_in;
         b_z2_ff   <= b_z2_in;
         b_last_ff <= a_last_ff;
      end
      if (c_ready && b_valid_ff) begin
         c_e2_ff   <= b_e2_ff;
         c_p2_ff   <= c_p2_in;
         c_last_ff <= b_last_ff;
      end
      if (d_ready && c_valid_ff) begin
         d_state_ff <= d_state_in;
      end
      if (o_ready && root_valid[R-1]) begin
         o_mass_ff <= o_mass_in;
         o_flag_ff <= root_state[R-1].spacelike;
         o_last_ff <= root_state[R-1].last;
      end
   end

   for (genvar i = 0; i < R; i++) begin : g_root
      logic                      up_valid;
      imass_pkg::root_state_type up_state;
      logic                      down_ready;

      if (i == 0) begin : g_first
         assign up_valid = d_valid_ff;
         assign up_state = d_state_ff;
      end else begin : g_next
         assign up_valid = root_valid[i-1];
         assign up_state = root_state[i-1];
      end

      if (i == R - 1) begin : g_last
         assign down_ready = o_ready;
      end else begin : g_mid
         assign down_ready = root_ready[i+1];
      end

      imass_root_stage u_stage (
         .clock       (clock),
         .reset       (reset),
         .up_valid    (up_valid),
         .up_state    (up_state),
         .stage_ready (root_ready[i]),
         .down_ready  (down_ready),
         .valid       (root_valid[i]),
         .state       (root_state[i])
      );
   end

   assign o_mass_in = imass_pkg::sat_mass(root_state[R-1].root);

   assign rsp_chan.valid          = o_valid_ff;
   assign rsp_chan.invariant_mass = o_mass_ff;
   assign rsp_chan.spacelike_flag = o_flag_ff;
   assign rsp_chan.last_event_out = o_last_ff;

endmodule

// ----- hw/rtl/imass_root_stage.sv -----
// One registered digit step of the pipelined floor square root.
module imass_root_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      up_valid,
   input  imass_pkg::root_state_type up_state,
   output logic                      stage_ready,
   input  logic                      down_ready,
   output logic                      valid,
   output imass_pkg::root_state_type state
);

   logic                                valid_ff, valid_in;
   imass_pkg::root_state_type           state_ff, state_in;
   logic [imass_pkg::REM_WIDTH-1:0]     cat;
   logic [imass_pkg::REM_WIDTH-1:0]     trial;

   assign stage_ready = !valid_ff || down_ready;
   assign valid_in    = stage_ready ? up_valid : valid_ff;

   // Bring down the next two radicand bits and try a one in the next root bit
   always_comb begin
      cat   = {up_state.rem[imass_pkg::ROOT_WIDTH-1:0],
               up_state.rad[imass_pkg::RAD_WIDTH-1 -: 2]};
      trial = {up_state.root, 2'b01};
      state_in           = up_state;
      state_in.rad       = {up_state.rad[imass_pkg::RAD_WIDTH-3:0], 2'b00};
      if (cat >= trial) begin
         state_in.rem  = cat - trial;
         state_in.root = {up_state.root[imass_pkg::ROOT_WIDTH-2:0], 1'b1};
      end else begin
         state_in.rem  = cat;
         state_in.root = {up_state.root[imass_pkg::ROOT_WIDTH-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready && up_valid) begin
         state_ff <= state_in;
      end
   end

   assign valid = valid_ff;
   assign state = state_ff;

endmodule

// ----- hw/rtl/imass_checker.sv -----
// Port-level checker for the invariant mass block, with its bind.
module imass_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input imass_pkg::mass_type invariant_mass,
   input logic                spacelike_flag
);

   localparam int CNT_WIDTH = $clog2(imass_pkg::PIPE_DEPTH + 1);

   logic [CNT_WIDTH-1:0] outstanding_ff, outstanding_in;
   logic                 take_in, take_out;

   assign take_in  = req_valid && req_ready;
   assign take_out = rsp_valid && rsp_ready;

   always_comb begin
      outstanding_in = outstanding_ff;
      if (take_in && !take_out) begin
         outstanding_in = outstanding_ff + CNT_WIDTH'(1);
      end else if (take_out && !take_in) begin
         outstanding_in = outstanding_ff - CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(invariant_mass) && $stable(spacelike_flag))
      else $error("result changed while stalled");

   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && spacelike_flag |-> invariant_mass == '0)
      else $error("spacelike result with nonzero mass");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> outstanding_ff != '0)
      else $error("result shown with no item in flight");

   a_capacity: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff <= CNT_WIDTH'(imass_pkg::PIPE_DEPTH))
      else $error("more items in flight than pipeline stages");

endmodule

bind invariant_mass_two_particles_top imass_checker u_imass_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .invariant_mass (rsp_chan.invariant_mass),
   .spacelike_flag (rsp_chan.spacelike_flag)
);

// ----- test/invariant_mass_two_particles_top_tb.sv -----
// Self-checking testbench for the pipelined two-particle invariant mass block.
module invariant_mass_two_particles_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      imass_pkg::component_type e1;
      imass_pkg::component_type px1;
      imass_pkg::component_type py1;
      imass_pkg::component_type pz1;
      imass_pkg::component_type e2;
      imass_pkg::component_type px2;
      imass_pkg::component_type py2;
      imass_pkg::component_type pz2;
      logic                     last;
   } collision_type;

   typedef struct packed {
      imass_pkg::mass_type mass;
      logic                spacelike;
      logic                last;
   } mass_result_type;

   localparam int SETTLE_CYCLES = imass_pkg::PIPE_DEPTH + 14;
   localparam int MAX_REPORTS   = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;

   imass_req_if req_if ();
   imass_rsp_if rsp_if ();

   invariant_mass_two_particles_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   mass_result_type pending_masses[$];
   int              sender_gap_pct = 0;
   int              rsp_stall_pct  = 0;
   int              error_count    = 0;
   int              report_count   = 0;
   mass_result_type want;
   mass_result_type got;

   always #2 clock = ~clock;

   // Exact E^2 - |p|^2 on the summed four-vector, then the integer floor root
   function automatic mass_result_type predict_mass(input collision_type c);
      longint            e_sum, x_sum, y_sum, z_sum;
      longint unsigned   e_sq, p_sq, diff, root, trial;
      mass_result_type   r;
      e_sum = longint'(c.e1) + longint'(c.e2);
      x_sum = longint'(c.px1) + longint'(c.px2);
      y_sum = longint'(c.py1) + longint'(c.py2);
      z_sum = longint'(c.pz1) + longint'(c.pz2);
      e_sq  = e_sum * e_sum;
      p_sq  = x_sum * x_sum + y_sum * y_sum + z_sum * z_sum;
      r.last = c.last;
      r.spacelike = (e_sq < p_sq);
      r.mass = '0;
      if (!r.spacelike) begin
         diff = e_sq - p_sq;
         root = 0;
         for (int b = 21; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= diff) begin
               root = trial;
            end
         end
         r.mass = (root > longint'(imass_pkg::MASS_MAX)) ? imass_pkg::MASS_MAX :
                  imass_pkg::mass_type'(root);
      end
      return r;
   endfunction

   // Signed value with magnitude below 2^bits
   function automatic imass_pkg::component_type ranged_component(input int bits);
      int m;
      m = $urandom_range((1 << bits) - 1);
      return imass_pkg::component_type'($urandom_range(1) ? -m : m);
   endfunction

   function automatic collision_type random_collision();
      collision_type c;
      int            pick, bits, sgn, axis, v, w, dir;
      pick = $urandom_range(99);
      c.last = ($urandom_range(7) == 0);
      if (pick < 45) begin
         // momenta well below the energies: timelike when both energies share a sign
         bits  = $urandom_range(2, 17);
         c.px1 = ranged_component(bits);
         c.py1 = ranged_component(bits);
         c.pz1 = ranged_component(bits);
         c.px2 = ranged_component(bits);
         c.py2 = ranged_component(bits);
         c.pz2 = ranged_component(bits);
         sgn   = $urandom_range(1);
         v     = $urandom_range(1 << (bits + 1), (1 << (bits + 2)) - 1);
         w     = $urandom_range(1 << (bits + 1), (1 << (bits + 2)) - 1);
         c.e1  = imass_pkg::component_type'(sgn ? -v : v);
         if ($urandom_range(4) == 0) begin
            sgn = $urandom_range(1);
         end
         c.e2  = imass_pkg::component_type'(sgn ? -w : w);
      end else if (pick < 65) begin
         // both particles along one axis with |p| = E, optionally nudged by one
         bits = $urandom_range(1, 18);
         v    = $urandom_range((1 << bits) - 1);
         w    = $urandom_range((1 << bits) - 1);
         sgn  = $urandom_range(1);
         dir  = $urandom_range(1);
         axis = $urandom_range(2);
         c.px1 = '0; c.py1 = '0; c.pz1 = '0;
         c.px2 = '0; c.py2 = '0; c.pz2 = '0;
         c.e1 = imass_pkg::component_type'(sgn ? -v : v);
         c.e2 = imass_pkg::component_type'(sgn ? -w : w);
         case (axis)
            0: begin
               c.px1 = imass_pkg::component_type'(dir ? -v : v);
               c.px2 = imass_pkg::component_type'(dir ? -w : w);
            end
            1: begin
               c.py1 = imass_pkg::component_type'(dir ? -v : v);
               c.py2 = imass_pkg::component_type'(dir ? -w : w);
            end
            default: begin
               c.pz1 = imass_pkg::component_type'(dir ? -v : v);
               c.pz2 = imass_pkg::component_type'(dir ? -w : w);
            end
         endcase
         if ($urandom_range(1)) begin
            c.e1 = c.e1 + imass_pkg::component_type'($urandom_range(2)) -
                   imass_pkg::component_type'(1);
         end
      end else if (pick < 85) begin
         c = collision_type'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
         c.last = ($urandom_range(7) == 0);
      end else begin
         bits  = $urandom_range(1, 19);
         c.e1  = ranged_component(bits);
         c.px1 = ranged_component(bits);
         c.py1 = ranged_component(bits);
         c.pz1 = ranged_component(bits);
         c.e2  = ranged_component(bits);
         c.px2 = ranged_component(bits);
         c.py2 = ranged_component(bits);
         c.pz2 = ranged_component(bits);
      end
      return c;
   endfunction

   task automatic send_event(input collision_type c);
      while ($urandom_range(99) < sender_gap_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.energy_first  <= c.e1;
      req_if.px_first      <= c.px1;
      req_if.py_first      <= c.py1;
      req_if.pz_first      <= c.pz1;
      req_if.energy_second <= c.e2;
      req_if.px_second     <= c.px2;
      req_if.py_second     <= c.py2;
      req_if.pz_second     <= c.pz2;
      req_if.last_event    <= c.last;
      do @(posedge clock); while (!req_if.ready);
      pending_masses.push_back(predict_mass(c));
   endtask

   // Hold the input off until every outstanding result has been returned
   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (pending_masses.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic send_pair(input imass_pkg::component_type e1,
                            input imass_pkg::component_type px1,
                            input imass_pkg::component_type py1,
                            input imass_pkg::component_type pz1,
                            input imass_pkg::component_type e2,
                            input imass_pkg::component_type px2,
                            input imass_pkg::component_type py2,
                            input imass_pkg::component_type pz2,
                            input logic last);
      send_event('{e1, px1, py1, pz1, e2, px2, py2, pz2, last});
   endtask

   task automatic test_corner_events();
      imass_pkg::component_type zero, cmax, cmin;
      zero = '0;
      cmax = {1'b0, {(imass_pkg::COMPONENT_WIDTH-1){1'b1}}};
      cmin = {1'b1, {(imass_pkg::COMPONENT_WIDTH-1){1'b0}}};
      sender_gap_pct = 0;
      rsp_stall_pct  = 0;
      // zero mass squared, all components zero
      send_pair(zero, zero, zero, zero, zero, zero, zero, zero, 1'b0);
      // largest mass: both energies at the negative extreme
      send_pair(cmin, zero, zero, zero, cmin, zero, zero, zero, 1'b1);
      send_pair(cmax, zero, zero, zero, cmax, zero, zero, zero, 1'b0);
      send_pair(cmax, cmax, cmax, cmax, cmax, cmax, cmax, cmax, 1'b1);
      send_pair(cmin, cmin, cmin, cmin, cmin, cmin, cmin, cmin, 1'b0);
      // momenta cancel to -1: mass squared 2^40 - 1
      send_pair(cmin, cmax, zero, zero, cmin, cmin, zero, zero, 1'b1);
      // energies cancel to -1
      send_pair(cmax, zero, zero, zero, cmin, zero, zero, zero, 1'b0);
      // light-like with non-zero components
      send_pair(20'sd300, 20'sd300, zero, zero, zero, zero, zero, zero, 1'b0);
      send_pair(20'sd5000, 20'sd3000, -20'sd4000, zero, zero, zero, zero, zero, 1'b1);
      send_pair(-20'sd7, zero, zero, 20'sd7, -20'sd9, zero, zero, 20'sd9, 1'b0);
      // slightly space-like
      send_pair(20'sd1, zero, zero, zero, zero, zero, zero, -20'sd2, 1'b0);
      send_pair(20'sd5000, 20'sd3000, 20'sd4000, zero, zero, zero, zero, 20'sd1, 1'b1);
      // non-square mass squared, floor taken
      send_pair(20'sd2, 20'sd1, zero, zero, zero, zero, zero, zero, 1'b0);
      send_pair(-20'sd3, zero, 20'sd1, zero, -20'sd8, zero, zero, 20'sd2, 1'b1);
      // alternating bit patterns
      send_pair(20'h55555, 20'hAAAAA, 20'h55555, 20'hAAAAA,
                20'hAAAAA, 20'h55555, 20'hAAAAA, 20'h55555, 1'b0);
      send_pair(20'hAAAAA, 20'h0F0F0, 20'h00F0F, 20'h00000,
                20'hAAAAA, 20'h0F0F0, 20'h00F0F, 20'h00000, 1'b1);
      drain_results();
   endtask

   task automatic run_random_events(input int count);
      repeat (count) begin
         send_event(random_collision());
      end
   endtask

   task automatic test_stalled_results();
      sender_gap_pct = 10;
      rsp_stall_pct  = 77;
      run_random_events(600);
      drain_results();
   endtask

   task automatic test_sparse_events();
      sender_gap_pct = 77;
      rsp_stall_pct  = 10;
      run_random_events(600);
   endtask

   task automatic test_full_rate();
      sender_gap_pct = 0;
      rsp_stall_pct  = 0;
      run_random_events(650);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.mass      = rsp_if.invariant_mass;
         got.spacelike = rsp_if.spacelike_flag;
         got.last      = rsp_if.last_event_out;
         if (pending_masses.size() == 0) begin
            error_count++;
            if (report_count < MAX_REPORTS) begin
               report_count++;
               $display("unexpected result: mass %0d spacelike %0b last %0b",
                        got.mass, got.spacelike, got.last);
            end
         end else begin
            want = pending_masses.pop_front();
            if (got.mass !== want.mass || got.spacelike !== want.spacelike ||
                got.last !== want.last) begin
               error_count++;
               if (report_count < MAX_REPORTS) begin
                  report_count++;
                  $display("mismatch: mass %0d/%0d spacelike %0b/%0b last %0b/%0b",
                           want.mass, got.mass, want.spacelike, got.spacelike,
                           want.last, got.last);
               end
            end
         end
      end
   end

   initial begin
      #800000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      req_if.valid         = 1'b0;
      req_if.energy_first  = '0;
      req_if.px_first      = '0;
      req_if.py_first      = '0;
      req_if.pz_first      = '0;
      req_if.energy_second = '0;
      req_if.px_second     = '0;
      req_if.py_second     = '0;
      req_if.pz_second     = '0;
      req_if.last_event    = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_corner_events();
      test_stalled_results();
      test_sparse_events();
      test_full_rate();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
